@@ hw/rtl/bmms_pkg.sv @@
// Shared types and constants for the brightness min/max stretch block.
// Used by bmms_div and brightness_min_max_stretch_core; no dependencies.
package bmms_pkg;

  localparam int unsigned ValueW   = 8;
  localparam int unsigned ProductW = 2 * ValueW;

  localparam logic [ValueW-1:0] SpanReset = 8'd200;
  localparam logic [ValueW-1:0] ValueMax  = 8'd255;
  localparam logic [ValueW-1:0] LowReset  = 8'd255;
  localparam logic [ValueW-1:0] HighReset = 8'd0;

  // tuser[0] of the input item
  localparam logic CmdGather = 1'b0;
  localparam logic CmdApply  = 1'b1;

  // request into the shared divider
  typedef struct packed {
    logic                start;
    logic [ProductW-1:0] dividend;
    logic [ValueW-1:0]   divisor;
  } div_req_t;

  // response from the shared divider
  typedef struct packed {
    logic              done;
    logic [ValueW-1:0] quot;
  } div_rsp_t;

endpackage

@@ hw/rtl/brightness_min_max_stretch_core.sv @@
// Min/max contrast stretch of 8-bit brightness: top level.
// Gather item: updates min/max (frame_start reloads both from the pixel), no result.
// Apply item: quotient of the 8-step shared divider to the output register;
// held in res_q while it stalls; no new item is taken until it is loaded.
// Reset: min 255, max 0, target_span 200, output empty; depends on bmms_pkg, bmms_div.
module brightness_min_max_stretch_core
  import bmms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,     // target_span
  // input items
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel_value
  input  logic [1:0] s_axis_tuser,   // [0] command, [1] frame_start
  // result items
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] stretched_value
);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StHold
  } state_e;

  state_e            state_q;
  logic [ValueW-1:0] span_q;
  logic [ValueW-1:0] low_q, high_q;
  logic [ValueW-1:0] res_q;
  logic              out_valid_q;
  logic [ValueW-1:0] out_data_q;

  logic              in_acc;
  logic              is_apply;
  logic              out_free;
  logic              out_load;
  logic              empty_range;
  logic [ValueW-1:0] pix;
  logic [ValueW-1:0] diff;
  logic [ProductW-1:0] product;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_apply      = (s_axis_tuser[0] == CmdApply);
  assign pix           = s_axis_tdata;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = ((state_q == StDiv) && div_rsp.done && out_free) ||
                         ((state_q == StHold) && out_free);

  // below-min values and an empty range go through the divider as 0 / 1
  assign empty_range = (high_q <= low_q) || (pix <= low_q);
  assign diff        = pix - low_q;
  assign product     = ProductW'(diff) * ProductW'(span_q);

  always_comb begin
    div_req.start = in_acc && is_apply;
    if (empty_range) begin
      div_req.dividend = '0;
      div_req.divisor  = ValueW'(1);
    end else begin
      div_req.dividend = product;
      div_req.divisor  = high_q - low_q;
    end
  end

  bmms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      span_q      <= SpanReset;
      low_q       <= LowReset;
      high_q      <= HighReset;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        span_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (is_apply) begin
              state_q <= StDiv;
            end else if (s_axis_tuser[1]) begin
              low_q  <= pix;
              high_q <= pix;
            end else begin
              if (pix < low_q)  low_q  <= pix;
              if (pix > high_q) high_q <= pix;
            end
          end
        end
        StDiv: begin
          if (div_rsp.done) begin
            if (out_free) begin
              out_data_q  <= div_rsp.quot;
              state_q     <= StIdle;
            end else begin
              res_q   <= div_rsp.quot;
              state_q <= StHold;
            end
          end
        end
        StHold: begin
          if (out_free) begin
            out_data_q  <= res_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ hw/rtl/bmms_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient saturated to 8 bits.
// Depends on bmms_pkg for widths and the request/response structs.
module bmms_div
  import bmms_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(ValueW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              sat_q, sat_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic [ValueW-1:0] dvd_q, dvd_d;   // low dividend bits shift out, quotient bits shift in
  logic [ValueW-1:0] div_q, div_d;
  logic [ValueW:0]   shifted;
  logic [ValueW:0]   trial;

  assign shifted = {rem_q, dvd_q[ValueW-1]};
  assign trial   = shifted - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      // a quotient above 8 bits shows in the upper half alone
      sat_d  = (req_i.dividend[ProductW-1:ValueW] >= req_i.divisor);
      rem_d  = req_i.dividend[ProductW-1:ValueW];
      dvd_d  = req_i.dividend[ValueW-1:0];
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial[ValueW]) begin
        rem_d = shifted[ValueW-1:0];
        dvd_d = {dvd_q[ValueW-2:0], 1'b0};
      end else begin
        rem_d = trial[ValueW-1:0];
        dvd_d = {dvd_q[ValueW-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ValueW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sat_q ? ValueMax : dvd_q;

endmodule

@@ test/brightness_min_max_stretch_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for brightness_min_max_stretch_core: stream items in, results checked
// against an in-bench min/max stretch predictor. Depends on bmms_pkg and the core RTL.
module brightness_min_max_stretch_core_tb;
  import bmms_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 12;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] pixel_value
  logic [1:0] s_axis_tuser;   // [0] command, [1] frame_start
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] stretched_value

  brightness_min_max_stretch_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0] min_seen;
  logic [7:0] max_seen;
  logic [7:0] span_reg;
  logic [7:0] stretch_q[$];

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          tx_gaps_on = 1'b0;
  bit          rx_stalls_on = 1'b0;
  int unsigned rx_hold_cycles = 0;
  logic [7:0]  want;

  function automatic logic [7:0] predict_stretch(input logic [7:0] v);
    int unsigned lo;
    int unsigned hi;
    int unsigned q;
    lo = 32'(min_seen);
    hi = 32'(max_seen);
    if (hi <= lo || int'(v) <= lo) return 8'd0;
    q = ((int'(v) - lo) * int'(span_reg)) / (hi - lo);
    if (q > ValueMax) q = 32'(ValueMax);
    return q[7:0];
  endfunction

  task automatic send_pixel(input logic cmd, input logic [7:0] v, input logic first);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= {first, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CmdApply) begin
      stretch_q.push_back(predict_stretch(v));
    end else if (first) begin
      min_seen = v;
      max_seen = v;
    end else begin
      if (v < min_seen) min_seen = v;
      if (v > max_seen) max_seen = v;
    end
  endtask

  // stop offering, wait for every result, then let the block settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (stretch_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_span(input logic [7:0] span);
    drain_results();
    cfg_data_i  <= span;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    span_reg = span;
  endtask

  // one frame: gather pass of k items, then m applies, most over the full value range
  task automatic send_frame(input int unsigned k, input int unsigned m);
    int unsigned lo_b;
    int unsigned hi_b;
    lo_b = $urandom_range(0, 255);
    hi_b = $urandom_range(lo_b, 255);
    send_pixel(CmdGather, 8'($urandom_range(lo_b, hi_b)), 1'b1);
    for (int i = 1; i < k; i++) send_pixel(CmdGather, 8'($urandom_range(lo_b, hi_b)), 1'b0);
    for (int i = 0; i < m; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_pixel(CmdApply, 8'($urandom_range(lo_b, hi_b)), 1'($urandom));
      else
        send_pixel(CmdApply, 8'($urandom_range(0, 255)), 1'($urandom));
    end
  endtask

  task automatic test_reset_empty_range();
    send_pixel(CmdApply, 8'd0, 1'b0);
    send_pixel(CmdApply, 8'd128, 1'b1);
    send_pixel(CmdApply, 8'd255, 1'b0);
    drain_results();
  endtask

  task automatic test_directed_cases();
    // full range, frame start on apply ignored
    send_pixel(CmdGather, 8'd0, 1'b1);
    send_pixel(CmdGather, 8'd255, 1'b0);
    send_pixel(CmdApply, 8'd0, 1'b1);
    send_pixel(CmdApply, 8'd255, 1'b1);
    send_pixel(CmdApply, 8'd128, 1'b0);
    // min equals max
    send_pixel(CmdGather, 8'd77, 1'b1);
    send_pixel(CmdApply, 8'd77, 1'b0);
    send_pixel(CmdApply, 8'd200, 1'b0);
    send_pixel(CmdApply, 8'd10, 1'b0);
    // narrow range: below min, mid-range, at max, saturation above max
    send_pixel(CmdGather, 8'd100, 1'b1);
    send_pixel(CmdGather, 8'd50, 1'b0);
    send_pixel(CmdApply, 8'd30, 1'b0);
    send_pixel(CmdApply, 8'd75, 1'b0);
    send_pixel(CmdApply, 8'd100, 1'b0);
    send_pixel(CmdApply, 8'd150, 1'b0);
    write_span(8'd0);
    send_pixel(CmdApply, 8'd75, 1'b0);
    write_span(8'd255);
    send_pixel(CmdApply, 8'd75, 1'b0);
    send_pixel(CmdApply, 8'd150, 1'b0);
    drain_results();
  endtask

  task automatic test_span_sweep();
    logic [7:0] spans[4];
    spans = '{8'd1, 8'd0, 8'd255, SpanReset};
    foreach (spans[i]) begin
      write_span(spans[i]);
      send_frame(3, 4);
    end
    drain_results();
  endtask

  // output held off for a long stretch while inputs keep coming
  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 300;
    send_pixel(CmdGather, 8'd20, 1'b1);
    send_pixel(CmdGather, 8'd220, 1'b0);
    for (int i = 0; i < 30; i++) send_pixel(CmdApply, 8'($urandom_range(0, 255)), 1'b0);
    drain_results();
  endtask

  // sender stops until every result is back, then resumes on the same frame
  task automatic test_sender_pause();
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    send_frame(5, 6);
    drain_results();
    for (int i = 0; i < 6; i++) send_pixel(CmdApply, 8'($urandom_range(0, 255)), 1'b0);
    drain_results();
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned k;
    int unsigned m;
    for (int phase = 0; phase < 4; phase++) begin
      write_span(8'($urandom_range(0, 255)));
      tx_gaps_on   = (phase != 1);
      rx_stalls_on = (phase != 1) && (phase != 2);
      sent = 0;
      while (sent < 180) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any field combination
          send_pixel(1'($urandom), 8'($urandom), 1'($urandom));
          sent++;
        end else begin
          k = $urandom_range(1, 8);
          m = $urandom_range(1, 12);
          send_frame(k, m);
          sent += k + m;
        end
      end
    end
    drain_results();
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (stretch_q.size() == 0) begin
        $error("unexpected item: stretched_value actual %0d", m_axis_tdata);
        mismatch_cnt++;
      end else begin
        want = stretch_q.pop_front();
        if (m_axis_tdata !== want) begin
          $error("stretched_value: expected %0d, actual %0d", want, m_axis_tdata);
          mismatch_cnt++;
        end
      end
    end
  end

  // output side: random stalls, or one long hold-off on request
  initial begin : rx_side
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles != 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_stalls_on ? $urandom_range(0, 6) : 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= 8'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    s_axis_tuser  <= 2'd0;
    min_seen = LowReset;
    max_seen = HighReset;
    span_reg = SpanReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_empty_range();
    test_directed_cases();
    test_span_sweep();
    test_output_backpressure();
    test_sender_pause();
    test_random_frames();

    drain_results();
    if (mismatch_cnt == 0 && stretch_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
